// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication: when ante holds, cons must hold in the same cycle.
`define PSHH_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define PSHH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/pshh_pkg.sv
// ----------------------------------------------------------------------------
// pshh_pkg
// Widths, register map, item types and helper functions for the
// pairwise shift-add string hash unit.
// ----------------------------------------------------------------------------
package pshh_pkg;

    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned HASH_W      = 32;
    localparam int unsigned LEN_W       = 32;
    localparam int unsigned PRI_SH_W    = 4;
    localparam int unsigned SEC_SH_W    = 3;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned APB_ADDR_W  = 1;

    localparam logic [PRI_SH_W-1:0]   PRI_MASK = 4'hf;
    localparam logic [SEC_SH_W-1:0]   SEC_MASK = 3'h7;

    localparam logic [CHAR_W-1:0]     ASCII_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0]     ASCII_UPPER_Z = 8'h5a;
    localparam logic [CHAR_W-1:0]     ASCII_CASE_OFS = 8'h20;

    // Register map (byte addresses)
    localparam logic [APB_ADDR_W-1:0] REG_FOLD_CASE = 1'b0;

    typedef struct packed {
        logic [CHAR_W-1:0] char_byte;
        logic              first_byte;
        logic              last_byte;
        logic              empty_string;
    } t_in_item;

    typedef struct packed {
        logic [HASH_W-1:0] primary_hash;
        logic [HASH_W-1:0] secondary_hash;
        logic [LEN_W-1:0]  string_length;
    } t_out_item;

    // Map ASCII upper case to lower case when enabled.
    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                    input logic en);
        logic [CHAR_W-1:0] res;
        res = c;
        if (en && (c inside {[ASCII_UPPER_A:ASCII_UPPER_Z]})) begin
            res = c + ASCII_CASE_OFS;
        end
        return res;
    endfunction

    // Widen a byte to hash width and shift it left.
    function automatic logic [HASH_W-1:0] shl_char(input logic [CHAR_W-1:0] v,
                                                   input logic [PRI_SH_W-1:0] sh);
        return HASH_W'(v) << sh;
    endfunction

endpackage

// File: hw/rtl/pshh_intf.sv
// ----------------------------------------------------------------------------
// Hash unit channel interfaces
// Valid/ready channels for string bytes in and hash results out.
// ----------------------------------------------------------------------------
interface hash_in_if;
    import pshh_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_byte;
    logic              first_byte;
    logic              last_byte;
    logic              empty_string;

    modport source (output valid, output char_byte, output first_byte,
                    output last_byte, output empty_string, input ready);
    modport sink   (input valid, input char_byte, input first_byte,
                    input last_byte, input empty_string, output ready);
endinterface

interface hash_out_if;
    import pshh_pkg::*;

    logic              valid;
    logic              ready;
    logic [HASH_W-1:0] primary_hash;
    logic [HASH_W-1:0] secondary_hash;
    logic [LEN_W-1:0]  string_length;

    modport source (output valid, output primary_hash, output secondary_hash,
                    output string_length, input ready);
    modport sink   (input valid, input primary_hash, input secondary_hash,
                    input string_length, output ready);
endinterface

// File: hw/rtl/pairwise_shift_add_string_hash_unit.sv
// ----------------------------------------------------------------------------
// Pairwise shift-add string hash unit
// Hashes a byte stream into two 32-bit shift-add hashes plus the length.
// ----------------------------------------------------------------------------
//  channel   dir  handshake         payload
//  i_byte    in   valid/ready       char_byte, first_byte, last_byte, empty_string
//  o_hash    out  valid/ready       primary_hash, secondary_hash, string_length
//  apb       in   psel/penable      fold_case at byte address 0
//
//  One item per cycle while no result is stalled; the last item of a string
//  is loaded into the input register when accepted, and its result moves
//  into the result register when it leaves the input register.
//  The per-item update is one shift per hash and at most a four-term add, all in one stage.
//  Synchronous active-low reset clears the string state, both valid flags and fold_case.
//  A stalled result holds only the input register; items that give no
//  result keep flowing while the result waits.
// ----------------------------------------------------------------------------
module pairwise_shift_add_string_hash_unit
    import pshh_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    hash_in_if.sink               i_byte,
    hash_out_if.source            o_hash,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic              r_fold_case;

    logic              r_s1_valid;
    t_in_item          r_s1;

    logic [HASH_W-1:0] r_pri_sum;
    logic [HASH_W-1:0] r_sec_sum;
    logic [CHAR_W-1:0] r_prev_char;
    logic [LEN_W-1:0]  r_byte_count;
    logic              r_in_string;

    logic              r_out_valid;
    t_out_item         r_out;

    logic [CHAR_W-1:0] c;
    logic              has_prev;
    logic [CHAR_W-1:0] base_char;
    logic [HASH_W-1:0] pri_acc;
    logic [HASH_W-1:0] sec_acc;
    logic [LEN_W-1:0]  n_byte_count;
    logic [HASH_W-1:0] len_term;
    logic [HASH_W-1:0] pri_fin;
    logic [HASH_W-1:0] sec_fin;
    logic              s1_emits;
    logic              s1_adv;
    logic              in_ready;
    t_out_item         n_out;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr == REG_FOLD_CASE) ? APB_DATA_W'(r_fold_case) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_case <= 1'b0;
        end else if (psel && penable && pwrite && pready && (paddr == REG_FOLD_CASE)) begin
            r_fold_case <= pwdata[0];
        end
    end

    // ---------------- hash datapath ----------------
    always_comb begin
        c         = fold_char(r_s1.char_byte, r_fold_case);
        has_prev  = r_in_string && !r_s1.first_byte;
        // a lone first byte pairs with itself for the final result
        base_char = has_prev ? r_prev_char : c;
        pri_acc   = (has_prev ? r_pri_sum : '0) + shl_char(base_char, c[PRI_SH_W-1:0] & PRI_MASK);
        sec_acc   = (has_prev ? r_sec_sum : '0)
                  + shl_char(base_char, PRI_SH_W'(c[SEC_SH_W-1:0] & SEC_MASK));
        n_byte_count = has_prev ? (r_byte_count + LEN_W'(1)) : LEN_W'(1);
        len_term  = has_prev ? HASH_W'(n_byte_count) : '0;
        pri_fin   = pri_acc + len_term + HASH_W'(c);
        sec_fin   = (sec_acc + len_term + HASH_W'(c)) | HASH_W'(1);

        if (r_s1.empty_string) begin
            n_out.primary_hash   = '0;
            n_out.secondary_hash = HASH_W'(1);
            n_out.string_length  = '0;
        end else begin
            n_out.primary_hash   = pri_fin;
            n_out.secondary_hash = sec_fin;
            n_out.string_length  = n_byte_count;
        end
    end

    assign s1_emits = r_s1_valid && (r_s1.empty_string || r_s1.last_byte);
    assign s1_adv   = r_s1_valid && (!s1_emits || !r_out_valid || o_hash.ready);
    assign in_ready = !r_s1_valid || s1_adv;

    assign i_byte.ready = in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_byte.valid) begin
            r_s1.char_byte    <= i_byte.char_byte;
            r_s1.first_byte   <= i_byte.first_byte;
            r_s1.last_byte    <= i_byte.last_byte;
            r_s1.empty_string <= i_byte.empty_string;
        end
    end

    // string state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pri_sum    <= '0;
            r_sec_sum    <= '0;
            r_prev_char  <= '0;
            r_byte_count <= '0;
            r_in_string  <= 1'b0;
        end else if (s1_adv) begin
            if (r_s1.empty_string || r_s1.last_byte) begin
                r_pri_sum    <= '0;
                r_sec_sum    <= '0;
                r_prev_char  <= '0;
                r_byte_count <= '0;
                r_in_string  <= 1'b0;
            end else begin
                r_pri_sum    <= has_prev ? pri_acc : '0;
                r_sec_sum    <= has_prev ? sec_acc : '0;
                r_prev_char  <= c;
                r_byte_count <= n_byte_count;
                r_in_string  <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && s1_emits) begin
            r_out_valid <= 1'b1;
        end else if (o_hash.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_emits) begin
            r_out <= n_out;
        end
    end

    assign o_hash.valid          = r_out_valid;
    assign o_hash.primary_hash   = r_out.primary_hash;
    assign o_hash.secondary_hash = r_out.secondary_hash;
    assign o_hash.string_length  = r_out.string_length;

endmodule

// File: hw/rtl/pshh_checker.sv
// ----------------------------------------------------------------------------
// pshh_checker
// Port-level checks for the pairwise shift-add string hash unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pshh_checker
    import pshh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_ready,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [HASH_W-1:0] i_primary_hash,
    input  logic [HASH_W-1:0] i_secondary_hash,
    input  logic [LEN_W-1:0]  i_string_length
);

    logic out_stall;
    assign out_stall = i_out_valid && !i_out_ready;

    `PSHH_ASSERT_NEXT(a_out_valid_hold, i_clk, i_rst_n, out_stall, i_out_valid, "result dropped while stalled")

    `PSHH_ASSERT_NEXT(a_out_data_hold, i_clk, i_rst_n, out_stall, $stable(i_primary_hash) && $stable(i_secondary_hash) && $stable(i_string_length), "result changed while stalled")

    `PSHH_ASSERT_SAME(a_sec_odd, i_clk, i_rst_n, i_out_valid, i_secondary_hash[0], "secondary hash not odd")

    `PSHH_ASSERT_SAME(a_ready_when_out_free, i_clk, i_rst_n, !i_out_valid, i_in_ready, "input stalled with empty result register")

endmodule

bind pairwise_shift_add_string_hash_unit pshh_checker u_pshh_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_byte.ready),
    .i_out_valid      (o_hash.valid),
    .i_out_ready      (o_hash.ready),
    .i_primary_hash   (o_hash.primary_hash),
    .i_secondary_hash (o_hash.secondary_hash),
    .i_string_length  (o_hash.string_length)
);
